### rtl/core/gdpm_pkg.sv
// ============================================================================
// gdpm_pkg : shared types and constants of the gapped DNA pattern matcher
// Holds the command codes, register indexes and the structs that pass
// between the configuration block, the alignment cells and the top level.
// ============================================================================
package gdpm_pkg;

  // Input word commands.
  typedef enum logic [1:0] {
    CMD_WRITE_PATTERN = 2'd0,
    CMD_SEQ_BASE      = 2'd1,
    CMD_RESTART       = 2'd2,
    CMD_UNUSED        = 2'd3
  } cmd_e;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [1:0] REG_HOLE_LIMIT     = 2'd1;
  localparam logic [1:0] REG_MAX_HOLE_WIDTH = 2'd2;

  localparam int unsigned CfgW    = 9;
  localparam int unsigned CountW  = 9;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [CfgW-1:0] PatternLengthReset = 9'd1;
  localparam logic [CfgW-1:0] HoleLimitReset     = 9'd0;
  localparam logic [CfgW-1:0] MaxHoleWidthReset  = 9'd0;

  typedef struct packed {
    logic [CfgW-1:0] pattern_length;
    logic [CfgW-1:0] hole_limit;
    logic [CfgW-1:0] max_hole_width;
  } cfg_t;

  // Progress of one alignment as it moves from cell to cell.
  typedef struct packed {
    logic              alive;
    logic [CountW-1:0] holes;
    logic [CountW-1:0] run;
  } cell_state_t;

endpackage

### rtl/core/gapped_dna_pattern_matcher.sv
// ============================================================================
// gapped_dna_pattern_matcher : streaming gapped DNA pattern matcher
// A row of alignment cells checks every sequence start against a loaded
// pattern, tolerating bounded mismatch runs, and reports accepted starts.
// ============================================================================
// The block takes one input word per clock cycle and keeps that rate for as
// long as the result side is ready. Every word is either a pattern base
// write, a sequence base or a restart. A row of MAX_PATTERN cells holds the
// pattern, one base per cell, and the alignments in flight: on each
// sequence base every cell advances the alignment handed to it by its left
// neighbour by one pattern base, and cell zero opens a new one. The cell
// at the end of the pattern in use holds the finished alignment, which a
// selector picks out and places in the output register once that register
// is free, so result words appear in order of start position. The latency
// is set by the cell row register and the output register; the cycle time
// by one base compare, a run and hole count update and the selector over
// the row. There is no clearing pass after reset. A waiting result word
// does not stop the next input word unless a second result would then
// have nowhere to go.
module gapped_dna_pattern_matcher
  import gdpm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN   = 256,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input words
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [1:0]          base_i,
  input  logic [7:0]          pattern_index_i,
  // Result words
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         match_position_o,
  output logic [8:0]          holes_found_o,
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CmpW = (LenW > CfgW) ? LenW : CfgW;

  cfg_t cfg;

  gdpm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake and command decode.
  logic in_acc, step, restart, pat_wr;

  assign in_acc  = in_valid_i && in_ready_o;
  assign step    = in_acc && (cmd_e'(cmd_i) == CMD_SEQ_BASE);
  assign restart = in_acc && (cmd_e'(cmd_i) == CMD_RESTART);
  assign pat_wr  = in_acc && (cmd_e'(cmd_i) == CMD_WRITE_PATTERN);

  // Pattern length in use, saturated to the size of the cell row.
  logic [LenW-1:0] len_eff;

  always_comb begin
    if (CmpW'(cfg.pattern_length) > CmpW'(MAX_PATTERN)) begin
      len_eff = LenW'(MAX_PATTERN);
    end else begin
      len_eff = LenW'(cfg.pattern_length);
    end
  end

  // Length, start position and pending flag of the sequence base last taken.
  logic [LenW-1:0]          len_q;
  logic [POSITION_BITS-1:0] bases_seen_q, pos_q;
  logic                     pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= LenW'(1);
      bases_seen_q <= '0;
      pend_q       <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (restart) begin
        bases_seen_q <= '0;
      end else if (step) begin
        len_q        <= len_eff;
        bases_seen_q <= bases_seen_q + 1'b1;
      end
    end
  end

  // The start of the alignment that completes on this base.
  always_ff @(posedge clk_i) begin
    if (step) begin
      pos_q <= bases_seen_q - POSITION_BITS'(len_eff) + 1'b1;
    end
  end

  // The cell row. Cell j compares pattern base j and registers the
  // alignment that has consumed j + 1 sequence bases.
  cell_state_t cell_q   [MAX_PATTERN];
  cell_state_t cell_in  [MAX_PATTERN];

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic we, act;

    assign we  = pat_wr && (32'(pattern_index_i) == 32'(j));
    assign act = (32'(j) < 32'(len_eff));

    if (j == 0) begin : g_head
      assign cell_in[j] = '{alive: 1'b1, holes: '0, run: '0};
    end else begin : g_link
      // An alignment that finished at the end of the pattern goes no further.
      always_comb begin
        cell_in[j]       = cell_q[j-1];
        cell_in[j].alive = cell_q[j-1].alive && (32'(j) < 32'(len_q));
      end
    end

    gdpm_cell u_cell (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .pat_we_i         (we),
      .pat_base_i       (base_i),
      .step_i           (step),
      .clear_i          (restart),
      .active_i         (act),
      .base_i           (base_i),
      .hole_limit_i     (cfg.hole_limit),
      .max_hole_width_i (cfg.max_hole_width),
      .prev_i           (cell_in[j]),
      .state_o          (cell_q[j])
    );
  end

  // Pick the finished alignment from the last cell in use.
  logic [LenW-1:0] last_cnt;
  cell_state_t     fin;
  logic            hit, out_free, drain, load;

  assign last_cnt = len_q - 1'b1;
  assign fin      = cell_q[last_cnt[IdxW-1:0]];
  assign hit      = pend_q && (len_q != '0) && fin.alive;
  assign out_free = !out_valid_o || out_ready_i;
  assign load     = hit && out_free;
  assign drain    = pend_q && (!hit || out_free);

  // A new word may come in once the pending result has somewhere to go.
  assign in_ready_o = !pend_q || drain;

  always_comb begin
    if (step) begin
      pend_d = 1'b1;
    end else if (drain) begin
      pend_d = 1'b0;
    end else begin
      pend_d = pend_q;
    end
  end

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_pos_q;
  logic [CountW-1:0] out_holes_q;

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_pos_q   <= 32'(pos_q);
      out_holes_q <= fin.holes;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_position_o = out_pos_q;
  assign holes_found_o    = out_holes_q;

endmodule

### rtl/core/gdpm_cfg.sv
// ============================================================================
// gdpm_cfg : configuration registers of the gapped DNA pattern matcher
// APB-style register file with an always-ready access phase.
// ============================================================================
module gdpm_cfg
  import gdpm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_PATTERN_LENGTH: cfg_d.pattern_length = pwdata[CfgW-1:0];
        REG_HOLE_LIMIT:     cfg_d.hole_limit     = pwdata[CfgW-1:0];
        REG_MAX_HOLE_WIDTH: cfg_d.max_hole_width = pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_length <= PatternLengthReset;
      cfg_q.hole_limit     <= HoleLimitReset;
      cfg_q.max_hole_width <= MaxHoleWidthReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN_LENGTH: prdata = ApbDataW'(cfg_q.pattern_length);
      REG_HOLE_LIMIT:     prdata = ApbDataW'(cfg_q.hole_limit);
      REG_MAX_HOLE_WIDTH: prdata = ApbDataW'(cfg_q.max_hole_width);
      default:            prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/gdpm_cell.sv
// ============================================================================
// gdpm_cell : one alignment cell of the gapped DNA pattern matcher
// Holds one pattern base, compares it with the incoming sequence base and
// registers the advanced alignment for its right-hand neighbour.
// ============================================================================
module gdpm_cell
  import gdpm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pat_we_i,
  input  logic [1:0]      pat_base_i,
  input  logic            step_i,
  input  logic            clear_i,
  input  logic            active_i,
  input  logic [1:0]      base_i,
  input  logic [CfgW-1:0] hole_limit_i,
  input  logic [CfgW-1:0] max_hole_width_i,
  input  cell_state_t     prev_i,
  output cell_state_t     state_o
);

  logic [1:0]      pat_q;
  cell_state_t     state_q, state_d;
  logic            mismatch;
  logic [CountW:0] run_n, holes_n;
  logic            keep;

  always_ff @(posedge clk_i) begin
    if (pat_we_i) begin
      pat_q <= pat_base_i;
    end
  end

  always_comb begin
    mismatch = (base_i != pat_q);
    run_n    = mismatch ? ({1'b0, prev_i.run} + 1'b1) : '0;
    holes_n  = {1'b0, prev_i.holes} + (CountW+1)'(mismatch && (prev_i.run == '0));
    keep     = prev_i.alive
               && !(mismatch && (run_n > {1'b0, max_hole_width_i}))
               && !(holes_n > {1'b0, hole_limit_i});

    state_d = state_q;
    if (clear_i) begin
      state_d.alive = 1'b0;
    end else if (step_i) begin
      state_d.alive = active_i && keep;
      state_d.holes = holes_n[CountW-1:0];
      state_d.run   = run_n[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule
